### rtl/rfts_pkg.sv
// shared types, codes and constants of the resource-fit task scheduler
package rfts_pkg;

    // default geometry of the task table
    localparam int POD_COUNT_DEF     = 4;
    localparam int SLOTS_PER_POD_DEF = 4;

    // worker budgets after reset
    localparam logic [15:0] W0_RAM_RST = 16'd4000;
    localparam logic [7:0]  W0_CPU_RST = 8'd16;
    localparam logic [15:0] W1_RAM_RST = 16'd3000;
    localparam logic [7:0]  W1_CPU_RST = 8'd8;

    typedef enum logic [1:0] {
        MODE_LOAD     = 2'd0,
        MODE_SCHED    = 2'd1,
        MODE_COMPLETE = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        KIND_LOAD     = 2'd0,
        KIND_ASSIGNED = 2'd1,
        KIND_NONE     = 2'd2,
        KIND_COMPLETE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_EMPTY    = 2'd0,
        ST_INACTIVE = 2'd1,
        ST_BUSY     = 2'd2,
        ST_DONE     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_W0_RAM = 2'd0,
        CFG_W0_CPU = 2'd1,
        CFG_W1_RAM = 2'd2,
        CFG_W1_CPU = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_LOAD,
        S_COMPLETE,
        S_SCAN,
        S_DECIDE,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [1:0]  pod_index;
        logic [1:0]  slot_index;
        logic [15:0] need_ram;
        logic [7:0]  need_cpu;
    } in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        worker_id;
        logic [1:0]  granted_pod;
        logic [1:0]  granted_slot;
        logic [15:0] free_ram;
        logic [7:0]  free_cpu;
        logic        all_finished;
        logic        last_of_run;
    } out_t;

    // one word of the task table
    typedef struct packed {
        logic [1:0]  status;
        logic        owner;
        logic [7:0]  cpu;
        logic [15:0] ram;
    } entry_t;

    // sequencer to compare unit
    typedef struct packed {
        logic init;
        logic hit;
        logic pod_end;
    } scan_ctl_t;

    // compare unit result
    typedef struct packed {
        logic        valid;
        logic [15:0] ram;
        logic [7:0]  cpu;
    } fit_stat_t;

endpackage

### rtl/rfts_ram.sv
// generic single write, single read memory with registered read data
module rfts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/rfts_fit.sv
// compare unit: per-pod lowest-ram candidate and best fitting candidate
module rfts_fit
    import rfts_pkg::*;
#(
    parameter int IDX_W  = 4,
    parameter int POD_W  = 2,
    parameter int SLOT_W = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  scan_ctl_t         ctl,
    input  entry_t            entry,
    input  logic [IDX_W-1:0]  hit_addr,
    input  logic [POD_W-1:0]  hit_pod,
    input  logic [SLOT_W-1:0] hit_slot,
    input  logic [15:0]       lim_ram,
    input  logic [7:0]        lim_cpu,
    output fit_stat_t         best,
    output logic [IDX_W-1:0]  best_addr,
    output logic [POD_W-1:0]  best_pod,
    output logic [SLOT_W-1:0] best_slot,
    output logic              pending
);

    logic              cand_valid_reg;
    logic [15:0]       cand_ram_reg;
    logic [7:0]        cand_cpu_reg;
    logic [IDX_W-1:0]  cand_addr_reg;
    logic [POD_W-1:0]  cand_pod_reg;

    logic              podc_go_reg;
    logic              podc_valid_reg;
    logic [15:0]       podc_ram_reg;
    logic [7:0]        podc_cpu_reg;
    logic [IDX_W-1:0]  podc_addr_reg;
    logic [POD_W-1:0]  podc_pod_reg;
    logic [SLOT_W-1:0] podc_slot_reg;
    logic [SLOT_W-1:0] cand_slot_reg;

    logic              best_valid_reg;
    logic [15:0]       best_ram_reg;
    logic [7:0]        best_cpu_reg;
    logic [IDX_W-1:0]  best_addr_reg;
    logic [POD_W-1:0]  best_pod_reg;
    logic [SLOT_W-1:0] best_slot_reg;

    logic              take;
    logic              eff_valid;
    logic [15:0]       eff_ram;
    logic [7:0]        eff_cpu;
    logic [IDX_W-1:0]  eff_addr;
    logic [POD_W-1:0]  eff_pod;
    logic [SLOT_W-1:0] eff_slot;
    logic              promote;

    // lowest ram within the pod, earlier slot wins a tie
    assign take = ctl.hit && (entry.status == ST_INACTIVE) &&
                  (!cand_valid_reg || (entry.ram < cand_ram_reg));

    assign eff_valid = take || cand_valid_reg;
    assign eff_ram   = take ? entry.ram : cand_ram_reg;
    assign eff_cpu   = take ? entry.cpu : cand_cpu_reg;
    assign eff_addr  = take ? hit_addr  : cand_addr_reg;
    assign eff_pod   = take ? hit_pod   : cand_pod_reg;
    assign eff_slot  = take ? hit_slot  : cand_slot_reg;

    // pod candidate against the worker's limits, earlier pod wins a tie
    assign promote = podc_go_reg && podc_valid_reg &&
                     (podc_ram_reg <= lim_ram) && (podc_cpu_reg <= lim_cpu) &&
                     (!best_valid_reg || (podc_ram_reg < best_ram_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_valid_reg <= 1'b0;
            podc_go_reg    <= 1'b0;
            podc_valid_reg <= 1'b0;
            best_valid_reg <= 1'b0;
        end
        else if (ctl.init)
        begin
            cand_valid_reg <= 1'b0;
            podc_go_reg    <= 1'b0;
            podc_valid_reg <= 1'b0;
            best_valid_reg <= 1'b0;
        end
        else
        begin
            podc_go_reg <= ctl.hit && ctl.pod_end;
            if (ctl.hit)
            begin
                if (ctl.pod_end)
                begin
                    podc_valid_reg <= eff_valid;
                    cand_valid_reg <= 1'b0;
                end
                else
                begin
                    cand_valid_reg <= eff_valid;
                end
            end
            if (promote)
            begin
                best_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.hit && !ctl.pod_end)
        begin
            cand_ram_reg  <= eff_ram;
            cand_cpu_reg  <= eff_cpu;
            cand_addr_reg <= eff_addr;
            cand_pod_reg  <= eff_pod;
            cand_slot_reg <= eff_slot;
        end
        if (ctl.hit && ctl.pod_end)
        begin
            podc_ram_reg  <= eff_ram;
            podc_cpu_reg  <= eff_cpu;
            podc_addr_reg <= eff_addr;
            podc_pod_reg  <= eff_pod;
            podc_slot_reg <= eff_slot;
        end
        if (promote)
        begin
            best_ram_reg  <= podc_ram_reg;
            best_cpu_reg  <= podc_cpu_reg;
            best_addr_reg <= podc_addr_reg;
            best_pod_reg  <= podc_pod_reg;
            best_slot_reg <= podc_slot_reg;
        end
    end

    assign best.valid = best_valid_reg;
    assign best.ram   = best_ram_reg;
    assign best.cpu   = best_cpu_reg;
    assign best_addr  = best_addr_reg;
    assign best_pod   = best_pod_reg;
    assign best_slot  = best_slot_reg;
    assign pending    = podc_go_reg;

endmodule

### rtl/resource_fit_task_scheduler.sv
// top level of the resource-fit task scheduler: sequencer, worker budgets, task table
//
//  channel | handshake           | beat
//  --------+---------------------+-------------------------------------------
//  in      | in_valid / in_stall | in_data: mode, pod, slot, ram and cpu need
//  out     | out_valid/out_stall | out_data: one result, last_of_run marks end
//  cfg     | cfg_valid/cfg_ready | cfg_index selects budget, cfg_data value
//
// load and completion: the item passes the fetch step, then the load or complete
// step, then the emit step, which loads the output register before the next item
// is taken; an unused mode is absorbed with no result
// a schedule round scans the whole table once per worker through one read port
// of the task memory; after reset a clearing pass marks every entry empty;
// no input beat is taken meanwhile, configuration writes are taken at once
// out_stall holds the sequencer in its emit step while the output register still
// holds a stalled beat; in_stall is high whenever an item is being worked on
module resource_fit_task_scheduler
    import rfts_pkg::*;
#(
    parameter int POD_COUNT     = POD_COUNT_DEF,
    parameter int SLOTS_PER_POD = SLOTS_PER_POD_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    // item channel
    input  logic       in_valid,
    output logic       in_stall,
    input  in_t        in_data,
    // result channel
    output logic       out_valid,
    input  logic       out_stall,
    output out_t       out_data,
    // budget registers
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int DEPTH   = POD_COUNT * SLOTS_PER_POD;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int POD_W   = (POD_COUNT > 1) ? $clog2(POD_COUNT) : 1;
    localparam int SLOT_W  = (SLOTS_PER_POD > 1) ? $clog2(SLOTS_PER_POD) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ENTRY_W = $bits(entry_t);

    // sequencer state
    state_t            state_reg, state_next;
    in_t               item_reg, item_next;
    logic [IDX_W-1:0]  e_reg, e_next;
    logic              inrange_reg, inrange_next;
    logic              worker_reg, worker_next;
    logic [IDX_W-1:0]  clr_addr_reg, clr_addr_next;

    // scan address generator and first pipeline stage
    logic [IDX_W-1:0]  issue_addr_reg, issue_addr_next;
    logic [POD_W-1:0]  issue_pod_reg, issue_pod_next;
    logic [SLOT_W-1:0] issue_slot_reg, issue_slot_next;
    logic              issue_done_reg, issue_done_next;
    logic              d1_valid_reg, d1_valid_next;
    logic              d1_last_reg, d1_last_next;
    logic [IDX_W-1:0]  d1_addr_reg, d1_addr_next;
    logic [POD_W-1:0]  d1_pod_reg, d1_pod_next;
    logic [SLOT_W-1:0] d1_slot_reg, d1_slot_next;

    // tasks that are inactive or in progress
    logic [CNT_W-1:0]  count_reg, count_next;

    // worker budgets left
    logic [15:0]       avail_ram0_reg, avail_ram0_next;
    logic [15:0]       avail_ram1_reg, avail_ram1_next;
    logic [7:0]        avail_cpu0_reg, avail_cpu0_next;
    logic [7:0]        avail_cpu1_reg, avail_cpu1_next;

    // pending result and output register
    out_t              res_reg, res_next;
    out_t              out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    // memory ports
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_entry;
    logic [IDX_W-1:0]  rd_addr;
    logic [ENTRY_W-1:0] rd_word;
    entry_t            rd_entry;

    // compare unit
    scan_ctl_t         ctl;
    logic              scan_init;
    fit_stat_t         best;
    logic [IDX_W-1:0]  best_addr;
    logic [POD_W-1:0]  best_pod;
    logic [SLOT_W-1:0] best_slot;
    logic              fit_pending;

    logic [15:0]       cur_ram;
    logic [7:0]        cur_cpu;
    logic [16:0]       ret_ram;
    logic [8:0]        ret_cpu;
    logic [15:0]       ret_ram_sat;
    logic [7:0]        ret_cpu_sat;
    logic              out_free;
    logic              grant;

    assign rd_entry = entry_t'(rd_word);

    rfts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (ENTRY_W'(wr_entry)),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    // budget of the worker being scanned
    assign cur_ram = worker_reg ? avail_ram1_reg : avail_ram0_reg;
    assign cur_cpu = worker_reg ? avail_cpu1_reg : avail_cpu0_reg;

    assign ctl.init    = scan_init;
    assign ctl.hit     = d1_valid_reg;
    assign ctl.pod_end = d1_last_reg;

    rfts_fit #(
        .IDX_W  (IDX_W),
        .POD_W  (POD_W),
        .SLOT_W (SLOT_W)
    ) u_fit (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .entry     (rd_entry),
        .hit_addr  (d1_addr_reg),
        .hit_pod   (d1_pod_reg),
        .hit_slot  (d1_slot_reg),
        .lim_ram   (cur_ram),
        .lim_cpu   (cur_cpu),
        .best      (best),
        .best_addr (best_addr),
        .best_pod  (best_pod),
        .best_slot (best_slot),
        .pending   (fit_pending)
    );

    // completion hands resources back to the owner, saturating at full scale
    assign ret_ram     = {1'b0, (rd_entry.owner ? avail_ram1_reg : avail_ram0_reg)}
                         + {1'b0, rd_entry.ram};
    assign ret_cpu     = {1'b0, (rd_entry.owner ? avail_cpu1_reg : avail_cpu0_reg)}
                         + {1'b0, rd_entry.cpu};
    assign ret_ram_sat = ret_ram[16] ? 16'hFFFF : ret_ram[15:0];
    assign ret_cpu_sat = ret_cpu[8] ? 8'hFF : ret_cpu[7:0];

    // strict check: both remainders must stay above zero
    assign grant = best.valid && (best.ram < cur_ram) && (best.cpu < cur_cpu);

    assign out_free = !out_valid_reg || !out_stall;
    assign rd_addr  = (state_reg == S_SCAN) ? issue_addr_reg : e_reg;

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        e_next          = e_reg;
        inrange_next    = inrange_reg;
        worker_next     = worker_reg;
        clr_addr_next   = clr_addr_reg;
        issue_addr_next = issue_addr_reg;
        issue_pod_next  = issue_pod_reg;
        issue_slot_next = issue_slot_reg;
        issue_done_next = issue_done_reg;
        d1_valid_next   = 1'b0;
        d1_last_next    = d1_last_reg;
        d1_addr_next    = d1_addr_reg;
        d1_pod_next     = d1_pod_reg;
        d1_slot_next    = d1_slot_reg;
        count_next      = count_reg;
        avail_ram0_next = avail_ram0_reg;
        avail_ram1_next = avail_ram1_reg;
        avail_cpu0_next = avail_cpu0_reg;
        avail_cpu1_next = avail_cpu1_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && out_stall;
        wr_en           = 1'b0;
        wr_addr         = e_reg;
        wr_entry        = '0;
        scan_init       = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                // mark every entry empty, one a cycle
                wr_en           = 1'b1;
                wr_addr         = clr_addr_reg;
                wr_entry.status = ST_EMPTY;
                if (clr_addr_reg == IDX_W'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + IDX_W'(1);
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next    = in_data;
                    inrange_next = (32'(in_data.pod_index) < POD_COUNT) &&
                                   (32'(in_data.slot_index) < SLOTS_PER_POD);
                    e_next       = IDX_W'(32'(in_data.pod_index) * SLOTS_PER_POD
                                          + 32'(in_data.slot_index));
                    unique case (in_data.mode)
                        MODE_LOAD,
                        MODE_COMPLETE:
                        begin
                            state_next = S_FETCH;
                        end
                        MODE_SCHED:
                        begin
                            worker_next     = 1'b0;
                            scan_init       = 1'b1;
                            issue_addr_next = '0;
                            issue_pod_next  = '0;
                            issue_slot_next = '0;
                            issue_done_next = 1'b0;
                            state_next      = S_SCAN;
                        end
                        default:
                        begin
                            // unused mode: beat absorbed, nothing happens
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_FETCH:
            begin
                // table read at e_reg under way
                priority if (item_reg.mode == MODE_LOAD)
                begin
                    state_next = S_LOAD;
                end
                else
                begin
                    state_next = S_COMPLETE;
                end
            end

            S_LOAD:
            begin
                if (inrange_reg)
                begin
                    wr_en           = 1'b1;
                    wr_entry.status = ST_INACTIVE;
                    wr_entry.owner  = 1'b0;
                    wr_entry.cpu    = item_reg.need_cpu;
                    wr_entry.ram    = item_reg.need_ram;
                    // an entry joins the open set unless it already was there
                    if ((rd_entry.status == ST_EMPTY) || (rd_entry.status == ST_DONE))
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                res_next              = '0;
                res_next.kind         = KIND_LOAD;
                res_next.granted_pod  = item_reg.pod_index;
                res_next.granted_slot = item_reg.slot_index;
                res_next.last_of_run  = 1'b1;
                state_next            = S_EMIT;
            end

            S_COMPLETE:
            begin
                res_next              = '0;
                res_next.kind         = KIND_COMPLETE;
                res_next.granted_pod  = item_reg.pod_index;
                res_next.granted_slot = item_reg.slot_index;
                res_next.last_of_run  = 1'b1;
                if (inrange_reg && (rd_entry.status == ST_BUSY))
                begin
                    wr_en           = 1'b1;
                    wr_entry        = rd_entry;
                    wr_entry.status = ST_DONE;
                    count_next      = count_reg - CNT_W'(1);
                    if (rd_entry.owner)
                    begin
                        avail_ram1_next = ret_ram_sat;
                        avail_cpu1_next = ret_cpu_sat;
                    end
                    else
                    begin
                        avail_ram0_next = ret_ram_sat;
                        avail_cpu0_next = ret_cpu_sat;
                    end
                    res_next.worker_id = rd_entry.owner;
                    res_next.free_ram  = ret_ram_sat;
                    res_next.free_cpu  = ret_cpu_sat;
                end
                state_next = S_EMIT;
            end

            S_SCAN:
            begin
                // one table read a cycle; the compare unit takes the registered read data
                if (!issue_done_reg)
                begin
                    d1_valid_next = 1'b1;
                    d1_addr_next  = issue_addr_reg;
                    d1_pod_next   = issue_pod_reg;
                    d1_slot_next  = issue_slot_reg;
                    d1_last_next  = (issue_slot_reg == SLOT_W'(SLOTS_PER_POD - 1));
                    if (issue_slot_reg == SLOT_W'(SLOTS_PER_POD - 1))
                    begin
                        issue_slot_next = '0;
                        issue_pod_next  = issue_pod_reg + POD_W'(1);
                    end
                    else
                    begin
                        issue_slot_next = issue_slot_reg + SLOT_W'(1);
                    end
                    if (issue_addr_reg == IDX_W'(DEPTH - 1))
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        issue_addr_next = issue_addr_reg + IDX_W'(1);
                    end
                end
                else if (!d1_valid_reg && !fit_pending)
                begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                res_next             = '0;
                res_next.worker_id   = worker_reg;
                res_next.last_of_run = worker_reg;
                if (grant)
                begin
                    wr_en           = 1'b1;
                    wr_addr         = best_addr;
                    wr_entry.status = ST_BUSY;
                    wr_entry.owner  = worker_reg;
                    wr_entry.cpu    = best.cpu;
                    wr_entry.ram    = best.ram;
                    if (worker_reg)
                    begin
                        avail_ram1_next = cur_ram - best.ram;
                        avail_cpu1_next = cur_cpu - best.cpu;
                    end
                    else
                    begin
                        avail_ram0_next = cur_ram - best.ram;
                        avail_cpu0_next = cur_cpu - best.cpu;
                    end
                    res_next.kind         = KIND_ASSIGNED;
                    res_next.granted_pod  = 2'(best_pod);
                    res_next.granted_slot = 2'(best_slot);
                    res_next.free_ram     = cur_ram - best.ram;
                    res_next.free_cpu     = cur_cpu - best.cpu;
                end
                else
                begin
                    res_next.kind     = KIND_NONE;
                    res_next.free_ram = cur_ram;
                    res_next.free_cpu = cur_cpu;
                end
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_next              = res_reg;
                    out_next.all_finished = (count_reg == '0);
                    out_valid_next        = 1'b1;
                    if (res_reg.last_of_run)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // second half of the round: worker one
                        worker_next     = 1'b1;
                        scan_init       = 1'b1;
                        issue_addr_next = '0;
                        issue_pod_next  = '0;
                        issue_slot_next = '0;
                        issue_done_next = 1'b0;
                        state_next      = S_SCAN;
                    end
                end
            end
        endcase

        // budget writes reload the worker's remaining amount
        if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_W0_RAM: avail_ram0_next = cfg_data;
                CFG_W0_CPU: avail_cpu0_next = cfg_data[7:0];
                CFG_W1_RAM: avail_ram1_next = cfg_data;
                CFG_W1_CPU: avail_cpu1_next = cfg_data[7:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            worker_reg     <= 1'b0;
            issue_done_reg <= 1'b1;
            d1_valid_reg   <= 1'b0;
            count_reg      <= '0;
            avail_ram0_reg <= W0_RAM_RST;
            avail_cpu0_reg <= W0_CPU_RST;
            avail_ram1_reg <= W1_RAM_RST;
            avail_cpu1_reg <= W1_CPU_RST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            worker_reg     <= worker_next;
            issue_done_reg <= issue_done_next;
            d1_valid_reg   <= d1_valid_next;
            count_reg      <= count_next;
            avail_ram0_reg <= avail_ram0_next;
            avail_cpu0_reg <= avail_cpu0_next;
            avail_ram1_reg <= avail_ram1_next;
            avail_cpu1_reg <= avail_cpu1_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        e_reg          <= e_next;
        inrange_reg    <= inrange_next;
        issue_addr_reg <= issue_addr_next;
        issue_pod_reg  <= issue_pod_next;
        issue_slot_reg <= issue_slot_next;
        d1_last_reg    <= d1_last_next;
        d1_addr_reg    <= d1_addr_next;
        d1_pod_reg     <= d1_pod_next;
        d1_slot_reg    <= d1_slot_next;
        res_reg        <= res_next;
        out_reg        <= out_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;

endmodule

### rtl/rfts_checker.sv
// port-level checks of the resource-fit task scheduler, bound to the top level
module rfts_checker
    import rfts_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_stall,
    input out_t out_data
);

    // a held result beat stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // only the worker zero half of a round is followed by another result
    a_first_of_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last_of_run |->
            (out_data.worker_id == 1'b0) &&
            ((out_data.kind == KIND_ASSIGNED) || (out_data.kind == KIND_NONE)))
        else $error("non-final beat is not the worker zero schedule result");

    // load ack carries no budget and ends its run
    a_load_ack: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.kind == KIND_LOAD) |->
            (out_data.worker_id == 1'b0) && (out_data.free_ram == 16'd0) &&
            (out_data.free_cpu == 8'd0) && out_data.last_of_run)
        else $error("malformed load ack");

    // no assignment reports pod and slot zero
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.kind == KIND_NONE) |->
            (out_data.granted_pod == 2'd0) && (out_data.granted_slot == 2'd0))
        else $error("no-assignment beat names a task");

endmodule

bind resource_fit_task_scheduler rfts_checker u_rfts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

### test/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench of the resource-fit task scheduler
module tb_top;
    import rfts_pkg::*;

    // table geometry, as built by default
    localparam int PODS  = POD_COUNT_DEF;
    localparam int SLOTS = SLOTS_PER_POD_DEF;
    localparam int TASKS = PODS * SLOTS;

    // the one mode code the package leaves out: the block drops such a beat
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // a schedule round is the slowest item; allow for it plus margin
    localparam int SETTLE_CYCLES = 2 * (TASKS + 5) + 20;
    // cycles without any beat on any channel before the run is abandoned
    localparam int QUIET_LIMIT = 5000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_t         in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_t        out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [15:0] cfg_data = 16'd0;

    // scheduler state as the testbench sees it
    logic [15:0] tk_ram   [TASKS];
    logic [7:0]  tk_cpu   [TASKS];
    status_t     tk_state [TASKS];
    logic        tk_owner [TASKS];
    logic [15:0] left_ram [2];
    logic [7:0]  left_cpu [2];

    // results owed by the block, oldest first
    out_t owed_replies[$];

    int fault_count = 0;

    // percentage chance of a gap before each item beat / of a stall per cycle
    int gap_pct   = 0;
    int stall_pct = 0;
    int stall_left = 0;

    resource_fit_task_scheduler uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // error reporting: the first ten are printed, the rest only counted
    // ------------------------------------------------------------------
    function automatic void report(string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("mismatch: %s", msg);
    endfunction

    function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
            report($sformatf("%s expected %0d, got %0d", name, want, got));
    endfunction

    // ------------------------------------------------------------------
    // scheduler behaviour
    // ------------------------------------------------------------------
    function automatic out_t make_reply(kind_t k, int w, int pod, int slot,
                                       logic [15:0] fr, logic [7:0] fc);
        out_t r;
        r.kind         = k;
        r.worker_id    = 1'(w);
        r.granted_pod  = 2'(pod);
        r.granted_slot = 2'(slot);
        r.free_ram     = fr;
        r.free_cpu     = fc;
        r.all_finished = 1'b0;
        r.last_of_run  = 1'b0;
        return r;
    endfunction

    // task a worker would take in this round, or -1
    function automatic int pick_task(int w);
        int best;
        int cand;
        int e;
        best = -1;
        for (int p = 0; p < PODS; p++)
        begin
            // lowest-ram inactive task of the pod, first slot wins a tie
            cand = -1;
            for (int s = 0; s < SLOTS; s++)
            begin
                e = p * SLOTS + s;
                if (tk_state[e] == ST_INACTIVE && (cand < 0 || tk_ram[e] < tk_ram[cand]))
                    cand = e;
            end
            // only the pod's own candidate is considered, even if it does not fit
            if (cand >= 0 && tk_ram[cand] <= left_ram[w] && tk_cpu[cand] <= left_cpu[w]
                && (best < 0 || tk_ram[cand] < tk_ram[best]))
                best = cand;
        end
        // the grant itself needs both remainders to stay strictly positive
        if (best >= 0 && (tk_ram[best] >= left_ram[w] || tk_cpu[best] >= left_cpu[w]))
            best = -1;
        return best;
    endfunction

    // apply one accepted item and queue the results it owes
    function automatic void scheduler_step(in_t it);
        out_t batch[$];
        out_t rep;
        int e;
        int t;
        int w;
        logic [16:0] sum_r;
        logic [8:0] sum_c;
        logic done_all;
        e = int'(it.pod_index) * SLOTS + int'(it.slot_index);
        case (it.mode)
            MODE_LOAD:
            begin
                // overwrite regardless of status; a busy task's resources are lost
                tk_ram[e]   = it.need_ram;
                tk_cpu[e]   = it.need_cpu;
                tk_state[e] = ST_INACTIVE;
                batch.push_back(make_reply(KIND_LOAD, 0, int'(it.pod_index),
                                           int'(it.slot_index), 16'd0, 8'd0));
            end
            MODE_SCHED:
            begin
                for (w = 0; w < 2; w++)
                begin
                    t = pick_task(w);
                    if (t >= 0)
                    begin
                        left_ram[w] = left_ram[w] - tk_ram[t];
                        left_cpu[w] = left_cpu[w] - tk_cpu[t];
                        tk_state[t] = ST_BUSY;
                        tk_owner[t] = 1'(w);
                        batch.push_back(make_reply(KIND_ASSIGNED, w, t / SLOTS, t % SLOTS,
                                                   left_ram[w], left_cpu[w]));
                    end
                    else
                        batch.push_back(make_reply(KIND_NONE, w, 0, 0,
                                                   left_ram[w], left_cpu[w]));
                end
            end
            MODE_COMPLETE:
            begin
                if (tk_state[e] == ST_BUSY)
                begin
                    // return to the owner, saturating at the field limits
                    w = int'(tk_owner[e]);
                    sum_r = {1'b0, left_ram[w]} + {1'b0, tk_ram[e]};
                    sum_c = {1'b0, left_cpu[w]} + {1'b0, tk_cpu[e]};
                    left_ram[w] = sum_r[16] ? 16'hFFFF : sum_r[15:0];
                    left_cpu[w] = sum_c[8] ? 8'hFF : sum_c[7:0];
                    tk_state[e] = ST_DONE;
                    batch.push_back(make_reply(KIND_COMPLETE, w, int'(it.pod_index),
                                               int'(it.slot_index),
                                               left_ram[w], left_cpu[w]));
                end
                else
                    batch.push_back(make_reply(KIND_COMPLETE, 0, int'(it.pod_index),
                                               int'(it.slot_index), 16'd0, 8'd0));
            end
            default:
            begin
                // unused mode: no result, no change
            end
        endcase
        done_all = 1'b1;
        foreach (tk_state[i])
            if (tk_state[i] == ST_INACTIVE || tk_state[i] == ST_BUSY)
                done_all = 1'b0;
        foreach (batch[k])
        begin
            rep = batch[k];
            rep.all_finished = done_all;
            rep.last_of_run  = (k == batch.size() - 1);
            owed_replies.push_back(rep);
        end
    endfunction

    // ------------------------------------------------------------------
    // idling
    // ------------------------------------------------------------------
    // mostly short bursts, now and then a long one
    function automatic int burst_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // result side back-pressure
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 99) < stall_pct)
        begin
            out_stall  <= 1'b1;
            stall_left <= burst_len() - 1;
        end
        else
            out_stall <= 1'b0;
    end

    // pick new idle levels for both sides; each side has none at all a quarter of the time
    function automatic void shuffle_idle();
        case ($urandom_range(0, 3))
            0: gap_pct = 0;
            3: gap_pct = 45;
            default: gap_pct = 10;
        endcase
        case ($urandom_range(0, 3))
            0: stall_pct = 0;
            3: stall_pct = 45;
            default: stall_pct = 10;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        out_t want;
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (owed_replies.size() == 0)
                report($sformatf("result beat %h with nothing outstanding", out_data));
            else
            begin
                want = owed_replies.pop_front();
                compare_field("kind", 16'(want.kind), 16'(out_data.kind));
                compare_field("worker_id", 16'(want.worker_id), 16'(out_data.worker_id));
                compare_field("granted_pod", 16'(want.granted_pod),
                              16'(out_data.granted_pod));
                compare_field("granted_slot", 16'(want.granted_slot),
                              16'(out_data.granted_slot));
                compare_field("free_ram", want.free_ram, out_data.free_ram);
                compare_field("free_cpu", 16'(want.free_cpu), 16'(out_data.free_cpu));
                compare_field("all_finished", 16'(want.all_finished),
                              16'(out_data.all_finished));
                compare_field("last_of_run", 16'(want.last_of_run),
                              16'(out_data.last_of_run));
            end
        end
    end

    // watchdog: any beat on any channel counts as progress
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)
                || (cfg_valid && cfg_ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // drivers; every task is entered and left just after a rising edge
    // ------------------------------------------------------------------
    task automatic send_item(in_t it);
        int g;
        g = ($urandom_range(0, 99) < gap_pct) ? burst_len() : 0;
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        // beat taken at this edge
        scheduler_step(it);
    endtask

    // wait for every owed result, then for any work left by a dropped beat
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (owed_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_budget(cfg_reg_t idx, logic [15:0] val);
        logic [7:0] pad;
        pad = 8'($urandom);
        // cpu registers keep the low byte only, so toggle the upper one freely
        if (idx == CFG_W0_CPU || idx == CFG_W1_CPU)
            val[15:8] = pad;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        case (idx)
            CFG_W0_RAM: left_ram[0] = val;
            CFG_W0_CPU: left_cpu[0] = val[7:0];
            CFG_W1_RAM: left_ram[1] = val;
            CFG_W1_CPU: left_cpu[1] = val[7:0];
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_budgets(logic [15:0] w0r, logic [7:0] w0c,
                                logic [15:0] w1r, logic [7:0] w1c);
        settle();
        write_budget(CFG_W0_RAM, w0r);
        write_budget(CFG_W0_CPU, {8'd0, w0c});
        write_budget(CFG_W1_RAM, w1r);
        write_budget(CFG_W1_CPU, {8'd0, w1c});
    endtask

    function automatic in_t make_in(logic [1:0] mode, int pod, int slot, int ram, int cpu);
        in_t it;
        it.mode       = mode;
        it.pod_index  = 2'(pod);
        it.slot_index = 2'(slot);
        it.need_ram   = 16'(ram);
        it.need_cpu   = 8'(cpu);
        return it;
    endfunction

    // mostly meaningful traffic: loads with needs that fit, completions of busy tasks
    function automatic in_t random_item();
        in_t it;
        int r;
        int e;
        int busy[$];
        it.pod_index  = 2'($urandom);
        it.slot_index = 2'($urandom);
        it.need_ram   = 16'($urandom);
        it.need_cpu   = 8'($urandom);
        r = $urandom_range(0, 99);
        if (r < 3)
            it.mode = MODE_UNUSED;
        else if (r < 42)
        begin
            it.mode = MODE_LOAD;
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                it.need_ram = 16'($urandom_range(0, 1500));
                it.need_cpu = 8'($urandom_range(0, 6));
            end
            else if (r >= 85)
            begin
                // field extremes
                case ($urandom_range(0, 3))
                    0: begin it.need_ram = 16'd0;     it.need_cpu = 8'd0;   end
                    1: begin it.need_ram = 16'd1;     it.need_cpu = 8'd1;   end
                    2: begin it.need_ram = 16'hFFFE;  it.need_cpu = 8'hFE;  end
                    default: begin it.need_ram = 16'hFFFF; it.need_cpu = 8'hFF; end
                endcase
            end
        end
        else if (r < 66)
            it.mode = MODE_SCHED;
        else
        begin
            it.mode = MODE_COMPLETE;
            foreach (tk_state[i])
                if (tk_state[i] == ST_BUSY)
                    busy.push_back(i);
            if (busy.size() > 0 && $urandom_range(0, 9) < 8)
            begin
                e = busy[$urandom_range(0, busy.size() - 1)];
                it.pod_index  = 2'(e / SLOTS);
                it.slot_index = 2'(e % SLOTS);
            end
        end
        return it;
    endfunction

    task automatic run_traffic(int n);
        for (int i = 0; i < n; i++)
        begin
            if (i % 50 == 0)
                shuffle_idle();
            send_item(random_item());
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // empty table with reset budgets: nothing to grant, nothing to complete
    task automatic check_idle_table();
        gap_pct   = 20;
        stall_pct = 20;
        send_item(make_in(MODE_SCHED, 0, 0, 0, 0));
        send_item(make_in(MODE_COMPLETE, 0, 0, 0, 0));
        send_item(make_in(MODE_COMPLETE, 3, 3, 65535, 255));
    endtask

    // tie-breaks within and across pods, fit, overwrite, repeat completion
    task automatic check_directed_fit();
        send_item(make_in(MODE_LOAD, 0, 0, 1000, 4));
        send_item(make_in(MODE_LOAD, 0, 1, 1000, 2));
        send_item(make_in(MODE_LOAD, 1, 0, 1000, 1));
        send_item(make_in(MODE_LOAD, 2, 3, 4000, 1));
        send_item(make_in(MODE_SCHED, 0, 0, 0, 0));
        send_item(make_in(MODE_SCHED, 3, 3, 65535, 255));
        send_item(make_in(MODE_COMPLETE, 0, 0, 0, 0));
        // already done: plain ack
        send_item(make_in(MODE_COMPLETE, 0, 0, 0, 0));
        // overwrite of a busy task
        send_item(make_in(MODE_LOAD, 0, 1, 65535, 255));
        send_item(make_in(MODE_LOAD, 3, 2, 0, 0));
        send_item(make_in(MODE_UNUSED, 2, 1, 23130, 165));
        send_item(make_in(MODE_SCHED, 0, 0, 0, 0));
    endtask

    // exact-fit refusal, then returns that overflow the budget fields
    task automatic check_budget_extremes();
        load_budgets(16'd4000, 8'hFF, 16'hFFFF, 8'd1);
        send_item(make_in(MODE_SCHED, 0, 0, 0, 0));
        send_item(make_in(MODE_LOAD, 1, 1, 100, 1));
        send_item(make_in(MODE_SCHED, 0, 0, 0, 0));
        load_budgets(16'hFFFF, 8'hFF, 16'hFFFF, 8'd1);
        send_item(make_in(MODE_COMPLETE, 1, 0, 0, 0));
        send_item(make_in(MODE_COMPLETE, 1, 1, 0, 0));
        send_item(make_in(MODE_COMPLETE, 3, 2, 0, 0));
        send_item(make_in(MODE_SCHED, 0, 0, 0, 0));
    endtask

    // random traffic under several budget settings, extremes among them
    task automatic check_random_phases();
        load_budgets(W0_RAM_RST, W0_CPU_RST, W1_RAM_RST, W1_CPU_RST);
        run_traffic(170);
        load_budgets(16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF);
        run_traffic(170);
        load_budgets(16'd0, 8'd0, 16'd0, 8'd0);
        run_traffic(60);
        load_budgets(16'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
        run_traffic(170);
        load_budgets(16'd1, 8'd1, 16'($urandom_range(500, 3000)), 8'($urandom_range(1, 8)));
        run_traffic(130);
    endtask

    initial
    begin
        foreach (tk_state[i])
        begin
            tk_ram[i]   = '0;
            tk_cpu[i]   = '0;
            tk_state[i] = ST_EMPTY;
            tk_owner[i] = 1'b0;
        end
        left_ram[0] = W0_RAM_RST;
        left_cpu[0] = W0_CPU_RST;
        left_ram[1] = W1_RAM_RST;
        left_cpu[1] = W1_CPU_RST;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        check_idle_table();
        check_directed_fit();
        check_budget_extremes();
        check_random_phases();
        settle();

        if (fault_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### resource_fit_task_scheduler.f
rtl/rfts_pkg.sv
rtl/rfts_ram.sv
rtl/rfts_fit.sv
rtl/resource_fit_task_scheduler.sv
rtl/rfts_checker.sv
test/tb_top.sv
